// File: design/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types, constants and the double-dabble step for the signed decimal
// to digit frame converter.
// ----------------------------------------------------------------------------
package sdd_pkg;

	localparam int NumberWidth = 16;
	localparam int MagWidth    = 14;
	localparam int DigitCount  = 4;
	localparam int BcdWidth    = 4 * DigitCount;
	localparam int AddrWidth   = 3;
	localparam int CodeWidth   = 4;

	localparam logic signed [NumberWidth-1:0] PosLimit = 16'sd9999;
	localparam logic signed [NumberWidth-1:0] NegLimit = -16'sd999;

	localparam logic [CodeWidth-1:0] DashCode  = 4'd10;
	localparam logic [AddrWidth-1:0] FirstAddr = 3'd4;
	localparam logic [AddrWidth-1:0] LastAddr  = 3'd1;

	// shift-add-3 steps per pipeline stage, together MagWidth
	localparam int StepsA = 5;
	localparam int StepsB = 5;
	localparam int StepsC = MagWidth - StepsA - StepsB;

	typedef struct packed {
		logic                neg;
		logic [BcdWidth-1:0] bcd;
		logic [MagWidth-1:0] bin;
	} sdd_work_t;

	function automatic sdd_work_t dd_step(sdd_work_t w);
		sdd_work_t           r;
		logic [BcdWidth-1:0] b;
		b = w.bcd;
		for (int d = 0; d < DigitCount; d++) begin
			if (b[d*4 +: 4] >= 4'd5) begin
				b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
			end
		end
		r.neg          = w.neg;
		{r.bcd, r.bin} = {b, w.bin} << 1;
		return r;
	endfunction

endpackage

// File: design/sdd_if.sv
// ----------------------------------------------------------------------------
// sdd_if
// Valid/ready channels: signed values in, digit-register frames out.
// ----------------------------------------------------------------------------
interface sdd_in_if;
	logic                   valid;
	logic                   ready;
	logic signed [15:0]     number;

	modport source(output valid, output number, input ready);
	modport sink(input valid, input number, output ready);
endinterface

interface sdd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] digit_address;
	logic [3:0] digit_code;
	logic       last_of_run;

	modport source(output valid, output digit_address, output digit_code,
		output last_of_run, input ready);
	modport sink(input valid, input digit_address, input digit_code,
		input last_of_run, output ready);
endinterface

// File: design/sdd_front.sv
// ----------------------------------------------------------------------------
// sdd_front
// First stage: range check, sign split and magnitude; out-of-range values
// are taken and dropped here.
// ----------------------------------------------------------------------------
module sdd_front import sdd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sdd_in_if.sink     values,
	output logic       out_valid,
	input  logic       out_ready,
	output sdd_work_t  out_work
);

	logic                   valid_s1;
	sdd_work_t              work_s1;
	logic                   adv;
	logic                   in_pos;
	logic                   in_neg;
	logic [NumberWidth-1:0] mag;

	assign adv          = !valid_s1 || out_ready;
	assign values.ready = adv;

	assign in_pos = !values.number[NumberWidth-1] && (values.number <= PosLimit);
	assign in_neg = values.number[NumberWidth-1] && (values.number >= NegLimit);
	assign mag    = values.number[NumberWidth-1] ? (~values.number + 16'd1)
		: values.number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= values.valid && (in_pos || in_neg);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && values.valid) begin
			work_s1.neg <= in_neg;
			work_s1.bcd <= '0;
			work_s1.bin <= mag[MagWidth-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

// File: design/sdd_dabble.sv
// ----------------------------------------------------------------------------
// sdd_dabble
// One pipeline stage of the binary to BCD conversion: a fixed number of
// shift-add-3 steps between registers.
// ----------------------------------------------------------------------------
module sdd_dabble import sdd_pkg::*; #(
	parameter int Steps = StepsA
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sdd_work_t  in_work,
	output logic       out_valid,
	input  logic       out_ready,
	output sdd_work_t  out_work
);

	logic      valid_s1;
	sdd_work_t work_s1;
	sdd_work_t work_next;
	logic      adv;

	assign adv      = !valid_s1 || out_ready;
	assign in_ready = adv;

	always_comb begin
		work_next = in_work;
		for (int i = 0; i < Steps; i++) begin
			work_next = dd_step(work_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			work_s1 <= work_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

// File: design/sdd_serial.sv
// ----------------------------------------------------------------------------
// sdd_serial
// Output serializer: holds one converted value and sends its four frames,
// address 4 down to 1.
// ----------------------------------------------------------------------------
module sdd_serial import sdd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sdd_work_t  in_work,
	sdd_out_if.source  frames
);

	logic [AddrWidth-1:0] cnt_q;
	logic [BcdWidth-1:0]  bcd_q;
	logic                 neg_q;
	logic                 load;
	logic                 take;

	assign take     = frames.valid && frames.ready;
	assign in_ready = (cnt_q == '0) || ((cnt_q == LastAddr) && frames.ready);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= FirstAddr;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_work.bcd;
			neg_q <= in_work.neg;
		end
	end

	assign frames.valid         = (cnt_q != '0);
	assign frames.digit_address = cnt_q;
	assign frames.last_of_run   = (cnt_q == LastAddr);

	always_comb begin
		case (cnt_q)
			3'd4:    frames.digit_code = neg_q ? DashCode : bcd_q[15:12];
			3'd3:    frames.digit_code = bcd_q[11:8];
			3'd2:    frames.digit_code = bcd_q[7:4];
			3'd1:    frames.digit_code = bcd_q[3:0];
			default: frames.digit_code = '0;
		endcase
	end

endmodule

// File: design/signed_decimal_to_digit_frames.sv
// ----------------------------------------------------------------------------
// signed_decimal_to_digit_frames
// Signed 16-bit value to four digit-register frames for a Code-B
// seven-segment driver; a negative value gets a leading dash.
// ----------------------------------------------------------------------------
// channel  dir  payload                                    handshake
// values   in   number (s16)                               valid/ready
// frames   out  digit_address, digit_code, last_of_run     valid/ready
//
// four register stages (range check, then 5, 5 and 4 shift-add-3 steps)
// feed a frame serializer; the serializer sends one frame per cycle while
// frames.ready is high and loads the next value as the last frame is taken;
// out-of-range values are taken and give no frames
// arst_n clears all valid bits and the frame counter
// a stall on frames holds the current frame and backs up stage by stage
// ----------------------------------------------------------------------------
module signed_decimal_to_digit_frames import sdd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sdd_in_if.sink     values,
	sdd_out_if.source  frames
);

	logic      v1, v2, v3, v4;
	logic      r1, r2, r3, r4;
	sdd_work_t w1, w2, w3, w4;

	sdd_front u_front (
		.clk(clk), .arst_n(arst_n), .values(values),
		.out_valid(v1), .out_ready(r1), .out_work(w1)
	);

	sdd_dabble #(.Steps(StepsA)) u_dabble_a (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v1), .in_ready(r1), .in_work(w1),
		.out_valid(v2), .out_ready(r2), .out_work(w2)
	);

	sdd_dabble #(.Steps(StepsB)) u_dabble_b (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v2), .in_ready(r2), .in_work(w2),
		.out_valid(v3), .out_ready(r3), .out_work(w3)
	);

	sdd_dabble #(.Steps(StepsC)) u_dabble_c (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v3), .in_ready(r3), .in_work(w3),
		.out_valid(v4), .out_ready(r4), .out_work(w4)
	);

	sdd_serial u_serial (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v4), .in_ready(r4), .in_work(w4),
		.frames(frames)
	);

endmodule

// File: design/sdd_checker.sv
// ----------------------------------------------------------------------------
// sdd_checker
// Port-level checks on the frame output of the converter, bound to the top.
// ----------------------------------------------------------------------------
module sdd_checker import sdd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       frm_valid,
	input logic       frm_ready,
	input logic [2:0] frm_addr,
	input logic [3:0] frm_code,
	input logic       frm_last
);

	// stalled frame holds
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && !frm_ready |=> frm_valid && $stable(frm_addr)
			&& $stable(frm_code) && $stable(frm_last))
		else $error("frame changed under stall");

	// last flag marks exactly the units frame
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid |-> (frm_last == (frm_addr == LastAddr)))
		else $error("last_of_run does not match units address");

	// a run counts down without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && frm_ready && !frm_last |=>
			frm_valid && (frm_addr == $past(frm_addr) - 3'd1))
		else $error("frame run broken");

	// dash only in the leftmost place, digits elsewhere
	assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid |-> (frm_code <= 4'd9) || ((frm_code == DashCode) && (frm_addr == FirstAddr)))
		else $error("bad digit code");

endmodule

bind signed_decimal_to_digit_frames sdd_checker u_sdd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.frm_valid(frames.valid),
	.frm_ready(frames.ready),
	.frm_addr(frames.digit_address),
	.frm_code(frames.digit_code),
	.frm_last(frames.last_of_run)
);
